FILE: hdl/arc_vertex_generator_assert.svh
// assertion macros used by the arc vertex generator
`ifndef ARC_VERTEX_GENERATOR_ASSERT_SVH
`define ARC_VERTEX_GENERATOR_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define AVG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never hold outside reset
`define AVG_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/avg_pkg.sv
`timescale 1ns / 1ps
package avg_pkg;

  // register indexes
  localparam logic [1:0] RegRadius = 2'd0;
  localparam logic [1:0] RegArcTurns = 2'd1;
  localparam logic [1:0] RegSegments = 2'd2;

  localparam logic [15:0] RadiusReset = 16'd256;
  localparam logic [15:0] ArcTurnsReset = 16'd32768;
  localparam logic [5:0] SegmentsReset = 6'd32;
  localparam logic [5:0] MinSeg = 6'd6;
  localparam logic [5:0] MinSteps = 6'd2;

  localparam logic [31:0] Q30One = 32'h4000_0000;
  localparam logic [32:0] TwoPiQ30 = 33'd6746518852;
  localparam logic [14:0] Quarter = 15'd16384;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StSteps,
    StDivide,
    StAngle,
    StSquare,
    StHorner,
    StHornerDiv,
    StSineOut,
    StScale,
    StEmit
  } state_e;

  // reciprocal of the horner divisor per step, highest order first:
  // ceil(2^(32+l) / d) with l = ceil(log2 d), exact for 32 bit numerators
  function automatic logic [32:0] horner_recip(input logic [2:0] k);
    logic [32:0] m;
    unique case (k)
      3'd0: m = 33'(((64'd1 << 40) + 64'd155) / 64'd156);
      3'd1: m = 33'(((64'd1 << 39) + 64'd109) / 64'd110);
      3'd2: m = 33'(((64'd1 << 39) + 64'd71) / 64'd72);
      3'd3: m = 33'(((64'd1 << 38) + 64'd41) / 64'd42);
      3'd4: m = 33'(((64'd1 << 37) + 64'd19) / 64'd20);
      default: m = 33'(((64'd1 << 35) + 64'd5) / 64'd6);
    endcase
    return m;
  endfunction

  // right shift that goes with each reciprocal
  function automatic logic [6:0] horner_shift(input logic [2:0] k);
    logic [6:0] s;
    unique case (k)
      3'd0: s = 7'd40;
      3'd1, 3'd2: s = 7'd39;
      3'd3: s = 7'd38;
      3'd4: s = 7'd37;
      default: s = 7'd35;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/avg_divider.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module avg_divider #(
  parameter int Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [Width-1:0] num_i,
  input  logic [Width-1:0] den_i,
  output logic             done_o,
  output logic [Width-1:0] quot_o
);
  localparam int CntW = $clog2(Width + 1);

  logic [Width-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [Width:0] trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q, quo_q[Width-1]} - {1'b0, den_q};
    if (go_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = CntW'(Width);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in the next numerator bit and try subtracting
      if (!trial[Width]) begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Width-2:0], quo_q[Width-1]};
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = quo_d;
endmodule

FILE: hdl/avg_multiplier.sv
`timescale 1ns / 1ps
// shared registered multiplier
module avg_multiplier (
  input  logic        clk_i,
  input  logic [32:0] a_i,
  input  logic [32:0] b_i,
  output logic [65:0] p_o
);
  logic [65:0] p_q;
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end
  assign p_o = p_q;
endmodule

FILE: hdl/arc_vertex_generator.sv
`timescale 1ns / 1ps
// Arc vertex generator: emits the vertices of a circular arc centred at the
// origin as a line strip.
// Configuration channel: cfg_valid_i/cfg_ready_o carry cfg_index_i (0 radius,
// 1 arc_turns, 2 segments_per_turn) and cfg_data_i; write only while idle.
// Command channel: an item is taken when start_i is high and busy_o is low;
// start_req_i = 0 produces no vertices.
// Each vertex appears for one cycle with vertex_valid_o; last_o marks the end.
// The receiver cannot stall; every vertex must be taken as shown.
// Per vertex: a phase division on the bit-serial divider, then sine and
// cosine in turn on the shared multiplier (angle, square, six Horner steps
// of a product and a reciprocal multiply, final product, scale), and an emit
// state. A request yields at most 63 vertices and stays busy until its last
// vertex has been emitted.
// Reset restores radius 256, arc_turns 32768, 32 segments, and goes idle.
module arc_vertex_generator #(
  parameter int MaxSegments = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        start_req_i,
  output logic        vertex_valid_o,
  output logic signed [16:0] vertex_x_o,
  output logic signed [16:0] vertex_y_o,
  output logic [5:0]  vertex_index_o,
  output logic        last_o
);
  `include "arc_vertex_generator_assert.svh"

  localparam logic [5:0] MaxSteps = 6'(MaxSegments - 1);

  logic [15:0] radius_q, turns_q;
  logic [5:0] seg_q;

  avg_pkg::state_e state_q, state_d;
  logic [5:0] steps_q, steps_d, idx_q, idx_d;
  logic [15:0] phase_q, phase_d;
  logic which_q, which_d;      // 0 sine of r, 1 sine of quarter minus r
  logic [32:0] x_q, x_d, x2_q, x2_d, t_q, t_d;
  logic [2:0] k_q, k_d;
  logic [16:0] mag_s_q, mag_s_d, mag_c_q, mag_c_d;
  logic wait_q, wait_d;        // multiplier result pending

  logic [32:0] ma, mb;
  logic [65:0] mp;
  logic dv_go;
  logic [31:0] dv_num, dv_den, dv_quot;
  logic dv_done;

  avg_multiplier u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));
  avg_divider #(.Width(32)) u_div (
    .clk_i, .rst_ni, .go_i(dv_go), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quot_o(dv_quot)
  );

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= avg_pkg::RadiusReset;
      turns_q <= avg_pkg::ArcTurnsReset;
      seg_q <= avg_pkg::SegmentsReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        avg_pkg::RegRadius: radius_q <= cfg_data_i;
        avg_pkg::RegArcTurns: turns_q <= cfg_data_i;
        avg_pkg::RegSegments: seg_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  logic [5:0] seg_eff;
  logic [21:0] steps_raw;
  logic [13:0] r_off;
  logic [14:0] r_arg;
  logic [1:0] quad;
  logic [31:0] hp, hq;
  logic [16:0] mag;
  logic [32:0] s_clamp;

  assign seg_eff = (seg_q < avg_pkg::MinSeg) ? avg_pkg::MinSeg : seg_q;
  assign quad = phase_q[15:14];
  assign r_off = phase_q[13:0];
  assign r_arg = which_q ? (avg_pkg::Quarter - {1'b0, r_off}) : {1'b0, r_off};
  assign hp = mp[61:30];
  assign hq = 32'(mp >> avg_pkg::horner_shift(k_q));
  assign mag = 17'((mp[65:29] + 37'd1) >> 1);

  // sequencer
  always_comb begin
    state_d = state_q;
    steps_d = steps_q;
    idx_d = idx_q;
    phase_d = phase_q;
    which_d = which_q;
    x_d = x_q;
    x2_d = x2_q;
    t_d = t_q;
    k_d = k_q;
    mag_s_d = mag_s_q;
    mag_c_d = mag_c_q;
    wait_d = 1'b0;
    ma = '0;
    mb = '0;
    dv_go = 1'b0;
    dv_num = {10'd0, 22'(idx_q) * 22'(turns_q)};
    dv_den = {26'd0, steps_q};
    steps_raw = 22'(seg_eff) * 22'(turns_q);
    s_clamp = '0;
    unique case (state_q)
      avg_pkg::StIdle: begin
        if (start_i && start_req_i) state_d = avg_pkg::StSteps;
      end
      avg_pkg::StSteps: begin
        if (steps_raw[21:16] < avg_pkg::MinSteps) steps_d = avg_pkg::MinSteps;
        else if (steps_raw[21:16] > MaxSteps) steps_d = MaxSteps;
        else steps_d = steps_raw[21:16];
        idx_d = '0;
        state_d = avg_pkg::StDivide;
        wait_d = 1'b1;
      end
      avg_pkg::StDivide: begin
        // phase = idx * turns / steps
        dv_go = wait_q;
        if (dv_done) begin
          phase_d = dv_quot[15:0];
          which_d = 1'b0;
          state_d = avg_pkg::StAngle;
        end
      end
      avg_pkg::StAngle: begin
        ma = {18'd0, r_arg};
        mb = avg_pkg::TwoPiQ30;
        if (wait_q) begin
          x_d = mp[48:16];
          state_d = avg_pkg::StSquare;
        end else wait_d = 1'b1;
      end
      avg_pkg::StSquare: begin
        ma = x_q;
        mb = x_q;
        if (wait_q) begin
          x2_d = {1'b0, mp[61:30]};
          t_d = {1'b0, avg_pkg::Q30One};
          k_d = '0;
          state_d = avg_pkg::StHorner;
        end else wait_d = 1'b1;
      end
      avg_pkg::StHorner: begin
        ma = x2_q;
        mb = t_q;
        if (wait_q) state_d = avg_pkg::StHornerDiv;
        else wait_d = 1'b1;
      end
      avg_pkg::StHornerDiv: begin
        // divide by the series constant through its reciprocal
        ma = {1'b0, hp};
        mb = avg_pkg::horner_recip(k_q);
        if (wait_q) begin
          t_d = (hq >= avg_pkg::Q30One) ? '0 : {1'b0, avg_pkg::Q30One - hq};
          k_d = k_q + 3'd1;
          if (k_q == 3'd5) state_d = avg_pkg::StSineOut;
          else state_d = avg_pkg::StHorner;
        end else wait_d = 1'b1;
      end
      avg_pkg::StSineOut: begin
        ma = x_q;
        mb = t_q;
        if (wait_q) begin
          x_d = {1'b0, mp[61:30]};
          state_d = avg_pkg::StScale;
        end else wait_d = 1'b1;
      end
      avg_pkg::StScale: begin
        s_clamp = (x_q > {1'b0, avg_pkg::Q30One}) ? {1'b0, avg_pkg::Q30One} : x_q;
        ma = {17'd0, radius_q};
        mb = s_clamp;
        if (wait_q) begin
          if (which_q) begin
            mag_c_d = mag;
            state_d = avg_pkg::StEmit;
          end else begin
            mag_s_d = mag;
            which_d = 1'b1;
            state_d = avg_pkg::StAngle;
          end
        end else wait_d = 1'b1;
      end
      avg_pkg::StEmit: begin
        idx_d = idx_q + 6'd1;
        if (idx_q == steps_q) state_d = avg_pkg::StIdle;
        else begin
          state_d = avg_pkg::StDivide;
          wait_d = 1'b1;
        end
      end
      default: state_d = avg_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= avg_pkg::StIdle;
      wait_q <= 1'b0;
      idx_q <= '0;
      steps_q <= avg_pkg::MinSteps;
    end else begin
      state_q <= state_d;
      wait_q <= wait_d;
      idx_q <= idx_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    which_q <= which_d;
    x_q <= x_d;
    x2_q <= x2_d;
    t_q <= t_d;
    k_q <= k_d;
    mag_s_q <= mag_s_d;
    mag_c_q <= mag_c_d;
  end

  // quadrant mapping of the two magnitudes onto x and y
  logic [16:0] vx, vy;
  always_comb begin
    unique case (quad)
      2'd0: begin vx = mag_c_q; vy = mag_s_q; end
      2'd1: begin vx = -mag_s_q; vy = mag_c_q; end
      2'd2: begin vx = -mag_c_q; vy = -mag_s_q; end
      default: begin vx = mag_s_q; vy = -mag_c_q; end
    endcase
  end

  assign busy_o = (state_q != avg_pkg::StIdle);
  assign vertex_valid_o = (state_q == avg_pkg::StEmit);
  assign vertex_x_o = vx;
  assign vertex_y_o = vy;
  assign vertex_index_o = idx_q;
  assign last_o = vertex_valid_o && (idx_q == steps_q);

  `AVG_ASSERT(a_last_ends, clk_i, rst_ni, last_o |=> !busy_o, "last vertex must end the run")
  `AVG_ASSERT(a_idx_bound, clk_i, rst_ni, vertex_valid_o |-> idx_q <= steps_q, "index past step count")
  `AVG_NEVER(a_steps_range, clk_i, rst_ni, busy_o && (steps_q < avg_pkg::MinSteps), "steps below minimum")
  `AVG_ASSERT(a_first_idx, clk_i, rst_ni, $rose(busy_o) |=> idx_q == 6'd0, "run must start at vertex zero")
endmodule

FILE: sim/arc_vertex_generator_tb.sv
`timescale 1ns / 1ps
module arc_vertex_generator_tb;

  localparam int unsigned CycleLimit = 10_000_000;
  localparam int unsigned RandomRequests = 290;
  localparam int MaxSegs = 63;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic [5:0]         index;
    logic               last;
  } vertex_t;

  // one directed row: a register write or a request, with an optional
  // typed value for the first vertex
  typedef struct {
    bit          is_write;
    logic [1:0]  reg_idx;
    logic [15:0] data;
    logic        req;
    bit          check_first;
    int          first_x;
    int          first_y;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = avg_pkg::RegRadius;
  logic [15:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic start_req_i = 1'b0;
  logic cfg_ready_o, busy_o, vertex_valid_o, last_o;
  logic signed [16:0] vertex_x_o, vertex_y_o;
  logic [5:0] vertex_index_o;

  vertex_t pending_vertices[$];
  logic [15:0] arc_radius = avg_pkg::RadiusReset;
  logic [15:0] sweep_turns = avg_pkg::ArcTurnsReset;
  logic [5:0] seg_per_turn = avg_pkg::SegmentsReset;
  bit failed = 1'b0;
  int unsigned cycle_count = 0;
  row_t rows[$];

  arc_vertex_generator dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** arc_vertex_generator: FAILED **");
      $finish;
    end
  end

  // sin(r turns/65536) in Q30, truncated Horner series
  function automatic logic [63:0] sine_q30(input logic [31:0] r);
    logic [63:0] ang, ang2, term, prod;
    int unsigned divs[6];
    divs = '{156, 110, 72, 42, 20, 6};
    if (r > 32'(avg_pkg::Quarter)) r = 32'(avg_pkg::Quarter);
    ang = (64'(r) * 64'(avg_pkg::TwoPiQ30)) >> 16;
    ang2 = (ang * ang) >> 30;
    term = 64'(avg_pkg::Q30One);
    for (int k = 0; k < 6; k++) begin
      prod = ((ang2 * term) >> 30) / divs[k];
      term = (prod >= 64'(avg_pkg::Q30One)) ? 64'd0 : 64'(avg_pkg::Q30One) - prod;
    end
    prod = (ang * term) >> 30;
    return (prod > 64'(avg_pkg::Q30One)) ? 64'(avg_pkg::Q30One) : prod;
  endfunction

  // rounded radius * s with sign applied
  function automatic logic signed [16:0] scale_radius(input logic [63:0] s, input bit neg);
    logic [63:0] mag;
    mag = (64'(arc_radius) * s + (64'd1 << 29)) >> 30;
    return neg ? 17'(-mag) : 17'(mag);
  endfunction

  // queue up every vertex of the arc for the current registers
  task automatic push_arc_vertices();
    logic [63:0] seg, steps, phase, sr, sc;
    vertex_t v;
    seg = (seg_per_turn < avg_pkg::MinSeg) ? 64'(avg_pkg::MinSeg) : 64'(seg_per_turn);
    steps = (seg * 64'(sweep_turns)) >> 16;
    if (steps < 64'(avg_pkg::MinSteps)) steps = 64'(avg_pkg::MinSteps);
    if (steps > 64'(MaxSegs - 1)) steps = 64'(MaxSegs - 1);
    for (int unsigned i = 0; 64'(i) <= steps; i++) begin
      phase = ((64'(i) * 64'(sweep_turns)) / steps) & 64'hFFFF;
      sr = sine_q30(32'(phase & 64'h3FFF));
      sc = sine_q30(32'(avg_pkg::Quarter) - 32'(phase & 64'h3FFF));
      unique case (phase[15:14])
        2'd0: begin v.x = scale_radius(sc, 0); v.y = scale_radius(sr, 0); end
        2'd1: begin v.x = scale_radius(sr, 1); v.y = scale_radius(sc, 0); end
        2'd2: begin v.x = scale_radius(sc, 1); v.y = scale_radius(sr, 1); end
        default: begin v.x = scale_radius(sr, 0); v.y = scale_radius(sc, 1); end
      endcase
      v.index = 6'(i);
      v.last = (64'(i) == steps);
      pending_vertices.push_back(v);
    end
  endtask

  // result checker, coordinates within one lsb
  always @(posedge clk_i) begin
    vertex_t exp_v;
    int dx, dy;
    if (rst_ni && vertex_valid_o) begin
      if (pending_vertices.size() == 0) begin
        $error("vertex with nothing expected: x %0d y %0d index %0d", vertex_x_o,
               vertex_y_o, vertex_index_o);
        failed = 1'b1;
      end else begin
        exp_v = pending_vertices.pop_front();
        dx = int'(vertex_x_o) - int'(exp_v.x);
        dy = int'(vertex_y_o) - int'(exp_v.y);
        if (dx > 1 || dx < -1) begin
          $error("vertex_x expected %0d got %0d", exp_v.x, vertex_x_o);
          failed = 1'b1;
        end
        if (dy > 1 || dy < -1) begin
          $error("vertex_y expected %0d got %0d", exp_v.y, vertex_y_o);
          failed = 1'b1;
        end
        if (vertex_index_o !== exp_v.index) begin
          $error("vertex_index expected %0d got %0d", exp_v.index, vertex_index_o);
          failed = 1'b1;
        end
        if (last_o !== exp_v.last) begin
          $error("last expected %0d got %0d", exp_v.last, last_o);
          failed = 1'b1;
        end
      end
    end
  end

  // wait for every vertex, then let the sequencer settle
  task automatic drain();
    while (pending_vertices.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    unique case (idx)
      avg_pkg::RegRadius:   arc_radius = data;
      avg_pkg::RegArcTurns: sweep_turns = data;
      avg_pkg::RegSegments: seg_per_turn = data[5:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one command beat; returns once accepted
  task automatic send_request(input logic req);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
    repeat (gap + 1) @(negedge clk_i);
    start_i <= 1'b1;
    start_req_i <= req;
    do @(posedge clk_i); while (busy_o);
    if (req) push_arc_vertices();
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  function automatic row_t wr(input logic [1:0] idx, input logic [15:0] data);
    row_t r;
    r = '{1'b1, idx, data, 1'b0, 1'b0, 0, 0};
    return r;
  endfunction

  function automatic row_t rq(input logic req, input bit chk, input int ex, input int ey);
    row_t r;
    r = '{1'b0, avg_pkg::RegRadius, 16'd0, req, chk, ex, ey};
    return r;
  endfunction

  initial begin
    row_t r;
    int first_seen;
    // directed part: reset values, extremes and special cases
    rows.push_back(rq(1, 1, 256, 0));
    rows.push_back(rq(0, 0, 0, 0));
    rows.push_back(wr(avg_pkg::RegSegments, 16'd1));
    rows.push_back(wr(avg_pkg::RegArcTurns, 16'd4000));
    rows.push_back(rq(1, 1, 256, 0));
    rows.push_back(wr(avg_pkg::RegArcTurns, 16'd0));
    rows.push_back(rq(1, 1, 256, 0));
    rows.push_back(wr(avg_pkg::RegRadius, 16'd0));
    rows.push_back(wr(avg_pkg::RegArcTurns, 16'd40000));
    rows.push_back(rq(1, 1, 0, 0));
    rows.push_back(wr(avg_pkg::RegRadius, 16'hFFFF));
    rows.push_back(wr(avg_pkg::RegArcTurns, 16'hFFFF));
    rows.push_back(wr(avg_pkg::RegSegments, 16'hFFFF));
    rows.push_back(rq(1, 1, 65535, 0));
    rows.push_back(wr(avg_pkg::RegSegments, 16'd5));
    rows.push_back(wr(avg_pkg::RegArcTurns, 16'd1));
    rows.push_back(rq(1, 1, 65535, 0));
    rows.push_back(wr(2'd3, 16'h5A5A));
    rows.push_back(wr(avg_pkg::RegRadius, 16'd1));
    rows.push_back(wr(avg_pkg::RegArcTurns, 16'd49152));
    rows.push_back(wr(avg_pkg::RegSegments, 16'd6));
    rows.push_back(rq(1, 1, 1, 0));
    rows.push_back(rq(0, 0, 0, 0));
    rows.push_back(rq(1, 0, 0, 0));

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[k]) begin
      r = rows[k];
      if (r.is_write) begin
        drain();
        write_reg(r.reg_idx, r.data);
      end else begin
        first_seen = pending_vertices.size();
        send_request(r.req);
        if (r.check_first && (pending_vertices[first_seen].x != r.first_x ||
                              pending_vertices[first_seen].y != r.first_y)) begin
          $error("first vertex expected (%0d, %0d) predicted (%0d, %0d)", r.first_x,
                 r.first_y, pending_vertices[first_seen].x, pending_vertices[first_seen].y);
          failed = 1'b1;
        end
      end
    end

    // random phases: new registers, then a burst of requests
    for (int n = 0; n < RandomRequests; ) begin
      drain();
      write_reg(avg_pkg::RegRadius, ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom));
      if ($urandom_range(0, 9) == 0)
        write_reg(avg_pkg::RegArcTurns, 16'($urandom));
      else
        write_reg(avg_pkg::RegArcTurns, 16'($urandom_range(1, 5000)));
      write_reg(avg_pkg::RegSegments, 16'($urandom));
      for (int b = $urandom_range(1, 25); b > 0 && n < RandomRequests; b--) begin
        send_request(($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1);
        n++;
      end
    end

    drain();
    repeat (100) @(negedge clk_i);
    if (!failed && pending_vertices.size() == 0) begin
      $display("** arc_vertex_generator: PASSED **");
    end else begin
      $display("** arc_vertex_generator: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/avg_pkg.sv
hdl/avg_divider.sv
hdl/avg_multiplier.sv
hdl/arc_vertex_generator.sv
sim/arc_vertex_generator_tb.sv
